### rtl/psev_pkg.sv
`default_nettype none

package psev_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int DATA_WIDTH  = 32;
    localparam int FIELD_W     = 32;

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W = $clog2(DATA_WIDTH);

    typedef enum logic [1:0] {
        TOK_NUMBER   = 2'd0,
        TOK_OPERATOR = 2'd1,
        TOK_END      = 2'd2
    } token_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    typedef struct packed {
        logic    push;
        logic    set_err;
        status_t err_code;
        logic    rd_en;
        logic    rd_next;
        logic    latch_op;
        logic    latch_right;
        logic    addsub_wb;
        logic    md_start;
        logic    md_wb;
        logic    emit;
    } psev_cmd_t;

    typedef struct packed {
        logic err_pending;
        logic full;
        logic lt2;
        logic right_zero;
        logic op_muldiv;
        logic op_div;
        logic md_done;
    } psev_stat_t;

    // Sign-extends or truncates a number token to the stack word.
    function automatic logic [DATA_WIDTH-1:0] to_data(input logic signed [FIELD_W-1:0] v);
        return DATA_WIDTH'(v);
    endfunction

    // The low bits of a stack word, zero-extended when the word is narrower.
    function automatic logic [FIELD_W-1:0] to_result(input logic [DATA_WIDTH-1:0] d);
        return FIELD_W'(d);
    endfunction

endpackage

`default_nettype wire

### rtl/psev_muldiv.sv
`default_nettype none

module psev_muldiv (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic                           is_div,
    input  wire logic [psev_pkg::DATA_WIDTH-1:0] a,
    input  wire logic [psev_pkg::DATA_WIDTH-1:0] b,
    output logic                                done,
    output logic [psev_pkg::DATA_WIDTH-1:0]      result
);
    import psev_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  div_reg, div_next;
    logic                  neg_reg, neg_next;
    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;

    logic [DATA_WIDTH-1:0] mag_a, mag_b;
    logic [DATA_WIDTH:0]   trial, diff;

    assign mag_a = a[DATA_WIDTH-1] ? (~a + DATA_WIDTH'(1)) : a;
    assign mag_b = b[DATA_WIDTH-1] ? (~b + DATA_WIDTH'(1)) : b;

    // Restoring division: acc holds the partial remainder, b shifts the
    // dividend out at the top and the quotient in at the bottom.
    assign trial = {acc_reg, b_reg[DATA_WIDTH-1]};
    assign diff  = trial - {1'b0, a_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_WIDTH - 1);
            div_next  = is_div;
            neg_next  = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
            acc_next  = '0;
            if (is_div)
            begin
                a_next = mag_b;
                b_next = mag_a;
            end
            else
            begin
                a_next = a;
                b_next = b;
            end
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (!diff[DATA_WIDTH])
                begin
                    acc_next = diff[DATA_WIDTH-1:0];
                    b_next   = {b_reg[DATA_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    acc_next = trial[DATA_WIDTH-1:0];
                    b_next   = {b_reg[DATA_WIDTH-2:0], 1'b0};
                end
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = {a_reg[DATA_WIDTH-2:0], 1'b0};
                b_next = {1'b0, b_reg[DATA_WIDTH-1:1]};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done   = done_reg;
    assign result = !div_reg ? acc_reg :
                    (neg_reg ? (~b_reg + DATA_WIDTH'(1)) : b_reg);

endmodule

`default_nettype wire

### rtl/psev_datapath.sv
`default_nettype none

module psev_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire psev_pkg::psev_cmd_t          cmd,
    output psev_pkg::psev_stat_t              stat,
    input  wire logic signed [psev_pkg::FIELD_W-1:0] number_value,
    input  wire logic [1:0]                   operator_code,
    output logic signed [psev_pkg::FIELD_W-1:0] result_value,
    output logic [1:0]                        status
);
    import psev_pkg::*;

    logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];

    logic [SP_W-1:0]       sp_reg;
    status_t               err_reg;
    op_t                   op_reg;
    logic [DATA_WIDTH-1:0] right_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [FIELD_W-1:0]    result_reg;
    status_t               status_reg;

    logic [SP_W-1:0]       sp_m1, sp_m2;
    logic [IDX_W-1:0]      rd_addr, wr_addr;
    logic                  wr_en;
    logic [DATA_WIDTH-1:0] wr_data, addsub, md_result;
    logic                  md_done;
    logic                  no_value;

    assign sp_m1   = sp_reg - SP_W'(1);
    assign sp_m2   = sp_reg - SP_W'(2);
    assign rd_addr = cmd.rd_next ? sp_m2[IDX_W-1:0] : sp_m1[IDX_W-1:0];

    // The left operand sits in the read register when add or subtract retires.
    assign addsub = (op_reg == OP_SUB) ? (rd_data_reg - right_reg) : (rd_data_reg + right_reg);

    assign wr_en   = cmd.push | cmd.addsub_wb | cmd.md_wb;
    assign wr_addr = cmd.push ? sp_reg[IDX_W-1:0] : sp_m2[IDX_W-1:0];
    assign wr_data = cmd.push ? to_data(number_value) : (cmd.addsub_wb ? addsub : md_result);

    psev_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.md_start),
        .is_div (op_reg == OP_DIV),
        .a      (rd_data_reg),
        .b      (right_reg),
        .done   (md_done),
        .result (md_result)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg  <= '0;
            err_reg <= ST_OK;
        end
        else if (cmd.emit)
        begin
            sp_reg  <= '0;
            err_reg <= ST_OK;
        end
        else
        begin
            if (cmd.push)
            begin
                sp_reg <= sp_reg + SP_W'(1);
            end
            else if (cmd.addsub_wb || cmd.md_wb)
            begin
                sp_reg <= sp_m1;
            end
            if (cmd.set_err)
            begin
                err_reg <= cmd.err_code;
            end
        end
    end

    assign no_value = (err_reg != ST_OK) || (sp_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.latch_op)
        begin
            op_reg <= op_t'(operator_code);
        end
        if (cmd.latch_right)
        begin
            right_reg <= rd_data_reg;
        end
        if (cmd.emit)
        begin
            result_reg <= no_value ? '0 : to_result(rd_data_reg);
            if (err_reg != ST_OK)
            begin
                status_reg <= err_reg;
            end
            else if (sp_reg == '0)
            begin
                status_reg <= ST_UNDER;
            end
            else
            begin
                status_reg <= ST_OK;
            end
        end
    end

    assign stat.err_pending = (err_reg != ST_OK);
    assign stat.full        = (sp_reg == SP_W'(STACK_DEPTH));
    assign stat.lt2         = (sp_reg < SP_W'(2));
    assign stat.right_zero  = (right_reg == '0);
    assign stat.op_muldiv   = (op_reg == OP_MUL) || (op_reg == OP_DIV);
    assign stat.op_div      = (op_reg == OP_DIV);
    assign stat.md_done     = md_done;

    assign result_value = result_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

### rtl/psev_ctrl.sv
`default_nettype none

module psev_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire logic [1:0]           req_type,
    output logic                      req_ready,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    input  wire psev_pkg::psev_stat_t stat,
    output psev_pkg::psev_cmd_t       cmd
);
    import psev_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LEFT,
        S_EXEC,
        S_WAIT_MD,
        S_END_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   accept, out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !res_valid_reg || res_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.err_code   = ST_OK;
        state_next     = state_reg;
        res_valid_next = res_valid_reg && !res_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        TOK_NUMBER:
                        begin
                            if (!stat.err_pending)
                            begin
                                if (stat.full)
                                begin
                                    cmd.set_err  = 1'b1;
                                    cmd.err_code = ST_OVER;
                                end
                                else
                                begin
                                    cmd.push = 1'b1;
                                end
                            end
                        end
                        TOK_OPERATOR:
                        begin
                            if (!stat.err_pending)
                            begin
                                if (stat.lt2)
                                begin
                                    cmd.set_err  = 1'b1;
                                    cmd.err_code = ST_UNDER;
                                end
                                else
                                begin
                                    cmd.latch_op = 1'b1;
                                    cmd.rd_en    = 1'b1;
                                    state_next   = S_RD_LEFT;
                                end
                            end
                        end
                        TOK_END:
                        begin
                            // The top is fetched even if it will not be shown.
                            cmd.rd_en  = 1'b1;
                            state_next = S_END_OUT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD_LEFT:
            begin
                cmd.latch_right = 1'b1;
                cmd.rd_en       = 1'b1;
                cmd.rd_next     = 1'b1;
                state_next      = S_EXEC;
            end
            S_EXEC:
            begin
                if (!stat.op_muldiv)
                begin
                    cmd.addsub_wb = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (stat.op_div && stat.right_zero)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ST_DIVZ;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.md_start = 1'b1;
                    state_next   = S_WAIT_MD;
                end
            end
            S_WAIT_MD:
            begin
                if (stat.md_done)
                begin
                    cmd.md_wb  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_END_OUT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

### rtl/postfix_stack_evaluator.sv
// Channel   Signals                                        Beat taken when
// req       req_valid req_ready req_type number_value      req_valid && req_ready
//           operator_code
// res       res_valid res_ready result_value status        res_valid && res_ready
//
// A number token is handled as it is taken. Add and subtract go through S_RD_LEFT
// and S_EXEC; multiply and divide then wait in S_WAIT_MD on the shift unit,
// which handles one bit per cycle. An operator that meets a pending error or too
// few operands is dropped as it is taken, and a divide by zero stops in S_EXEC.
// An end token waits in S_END_OUT until the result register is free.
// The operand stack sits in a single-port-read memory, so operands come out
// one per cycle. Reset empties the stack at once; the stored words need no clearing.
// A stalled result holds its register, and tokens keep being taken behind it
// until the next end token arrives.
`default_nettype none

module postfix_stack_evaluator (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  req_valid,
    output logic                                       req_ready,
    input  wire logic [1:0]                            req_type,
    input  wire logic signed [psev_pkg::FIELD_W-1:0]   number_value,
    input  wire logic [1:0]                            operator_code,
    output logic                                       res_valid,
    input  wire logic                                  res_ready,
    output logic signed [psev_pkg::FIELD_W-1:0]        result_value,
    output logic [1:0]                                 status
);
    import psev_pkg::*;

    psev_cmd_t  cmd;
    psev_stat_t stat;

    psev_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_type),
        .req_ready (req_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    psev_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .number_value  (number_value),
        .operator_code (operator_code),
        .result_value  (result_value),
        .status        (status)
    );

endmodule

`default_nettype wire

### rtl/psev_checker.sv
`default_nettype none

module psev_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                req_valid,
    input wire logic                                req_ready,
    input wire logic [1:0]                          req_type,
    input wire logic                                res_valid,
    input wire logic                                res_ready,
    input wire logic signed [psev_pkg::FIELD_W-1:0] result_value,
    input wire logic [1:0]                          status
);
    import psev_pkg::*;

    logic req_beat, end_beat;

    assign req_beat = req_valid && req_ready;
    assign end_beat = req_beat && (req_type == TOK_END);

    // A held result beat keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(result_value) && $stable(status))
        else $error("result beat changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status != ST_OK) |-> (result_value == '0))
        else $error("error result carries a non-zero value");

    // Only an end token can raise a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_beat && (req_type != TOK_END) && !res_valid |=> !res_valid)
        else $error("result appeared without an end token");

    assert property (@(posedge clk) disable iff (!rst_n)
        end_beat && !res_valid |-> ##2 res_valid)
        else $error("end token result late");

    assert property (@(posedge clk) disable iff (!rst_n)
        end_beat |=> !req_ready)
        else $error("token taken while an end token is still pending");

endmodule

bind postfix_stack_evaluator psev_checker u_psev_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req_type     (req_type),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .result_value (result_value),
    .status       (status)
);

`default_nettype wire
